// ===== design/mlu_pkg.sv =====
// mutex lock unit package: codes, widths and parameter defaults
package mlu_pkg;

	localparam int THREAD_ID_BITS_DEF = 8;
	localparam int COUNT_BITS_DEF     = 16;

	localparam int OP_BITS     = 2;
	localparam int KIND_BITS   = 2;
	localparam int STATUS_BITS = 3;
	localparam int TID_BITS    = 8;
	localparam int LOCK_BITS   = 9;

	typedef logic [OP_BITS-1:0]     op_t;
	typedef logic [KIND_BITS-1:0]   kind_t;
	typedef logic [STATUS_BITS-1:0] status_t;
	typedef logic signed [LOCK_BITS-1:0] lock_t;

	localparam op_t OP_LOCK    = 2'd0;
	localparam op_t OP_UNLOCK  = 2'd1;
	localparam op_t OP_TRYLOCK = 2'd2;

	localparam kind_t KIND_NORMAL    = 2'd0;
	localparam kind_t KIND_ERRCHECK  = 2'd1;
	localparam kind_t KIND_RECURSIVE = 2'd2;

	localparam status_t ST_OK       = 3'd0;
	localparam status_t ST_BUSY     = 3'd1;
	localparam status_t ST_DEADLOCK = 3'd2;
	localparam status_t ST_NOPERM   = 3'd3;
	localparam status_t ST_WAIT     = 3'd4;

	localparam lock_t LOCK_FREE = 9'sd1;
	localparam lock_t LOCK_HELD = 9'sd0;
	localparam lock_t LOCK_MIN  = -9'sd256;
	localparam lock_t LOCK_MAX  = 9'sd255;

endpackage

// ===== design/mutex_lock_unit_top.sv =====
// mutex lock unit top level: request pipeline, mutex state and result register
//
// Requests (operation, thread_id) arrive on a valid/ready channel; each
// accepted transaction yields exactly one result transaction (status,
// wake_one) on the output valid/ready channel, in order.
// The mutex kind is written through the cfg_valid/cfg_ready channel
// (cfg_ready is always high); write it only while no request is in flight.
// A request is held in the input register, and its result is captured in the
// result register, which drives the outputs. Throughput: one request per cycle
// while results are taken, updating lock value, owner and count per request.
// A result held by a stalled receiver stays in the result register; one more
// request can sit in the input register, after which in_ready drops until
// the receiver takes the result.
// Reset (arst_n low) empties both registers, frees the lock (value 1), clears
// the owner and the recursion count, and selects the normal kind.
module mutex_lock_unit_top #(
	parameter int THREAD_ID_BITS = mlu_pkg::THREAD_ID_BITS_DEF,
	parameter int COUNT_BITS     = mlu_pkg::COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  mlu_pkg::op_t                  operation,
	input  logic [mlu_pkg::TID_BITS-1:0]  thread_id,
	output logic                          out_valid,
	input  logic                          out_ready,
	output mlu_pkg::status_t              status,
	output logic                          wake_one,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  mlu_pkg::kind_t                mutex_kind
);
	import mlu_pkg::*;

	localparam int TID_EXT_BITS = (THREAD_ID_BITS > TID_BITS) ? THREAD_ID_BITS : TID_BITS;

	kind_t                     kind_q;
	logic                      valid_s1;
	op_t                       op_s1;
	logic [THREAD_ID_BITS-1:0] tid_s1;
	logic                      valid_s2;
	status_t                   status_s2;
	logic                      wake_s2;

	lock_t                     lock_q;
	logic [THREAD_ID_BITS-1:0] owner_q;
	logic [COUNT_BITS-1:0]     count_q;

	logic [TID_EXT_BITS-1:0]   tid_ext;
	logic                      adv;
	lock_t                     lock_dec;
	lock_t                     lock_inc;
	logic [COUNT_BITS-1:0]     count_inc;
	logic                      owned;
	logic                      mine;
	logic                      rec;
	lock_t                     lock_n;
	logic [THREAD_ID_BITS-1:0] owner_n;
	logic [COUNT_BITS-1:0]     count_n;
	status_t                   st_n;
	logic                      wake_n;

	assign cfg_ready = 1'b1;
	assign adv       = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || adv;
	assign tid_ext   = TID_EXT_BITS'(thread_id);

	assign out_valid = valid_s2;
	assign status    = status_s2;
	assign wake_one  = wake_s2;

	// saturating neighbors of the current state
	assign lock_dec  = (lock_q != LOCK_MIN) ? lock_q - 9'sd1 : lock_q;
	assign lock_inc  = (lock_q != LOCK_MAX) ? lock_q + 9'sd1 : lock_q;
	assign count_inc = (count_q != '1) ? count_q + COUNT_BITS'(1) : count_q;

	assign owned = (owner_q != '0);
	assign mine  = owned && (owner_q == tid_s1);
	assign rec   = (kind_q == KIND_RECURSIVE);

	always_comb begin
		lock_n  = lock_q;
		owner_n = owner_q;
		count_n = count_q;
		st_n    = ST_OK;
		wake_n  = 1'b0;
		if (op_s1 == OP_LOCK || op_s1 == OP_UNLOCK || op_s1 == OP_TRYLOCK) begin
			case (kind_q)
				KIND_NORMAL: begin
					if (op_s1 == OP_LOCK) begin
						lock_n = lock_dec;
						st_n   = (lock_dec != LOCK_HELD) ? ST_WAIT : ST_OK;
					end else if (op_s1 == OP_UNLOCK) begin
						lock_n = lock_inc;
						wake_n = (lock_inc != LOCK_FREE);
					end else if (lock_q != LOCK_FREE) begin
						st_n = ST_BUSY;
					end else begin
						lock_n = lock_dec;
					end
				end
				KIND_ERRCHECK, KIND_RECURSIVE: begin
					if (op_s1 == OP_UNLOCK) begin
						if (lock_q == LOCK_FREE) begin
							st_n = ST_NOPERM;
						end else if (rec && mine && count_q != '0) begin
							count_n = count_q - COUNT_BITS'(1);
						end else begin
							lock_n  = lock_inc;
							wake_n  = (lock_inc != LOCK_FREE);
							owner_n = '0;
						end
					end else if (owned) begin
						if (mine) begin
							if (rec) begin
								count_n = count_inc;
							end else begin
								st_n = ST_DEADLOCK;
							end
						end else begin
							st_n = ST_NOPERM;
						end
					end else if (op_s1 == OP_LOCK) begin
						if (rec && count_q != '0) begin
							st_n = ST_DEADLOCK;
						end else begin
							lock_n = lock_dec;
							if (lock_dec != LOCK_HELD) begin
								st_n = ST_WAIT;
							end else begin
								owner_n = tid_s1;
							end
						end
					end else if (lock_q != LOCK_FREE) begin
						st_n = ST_BUSY;
					end else begin
						lock_n  = lock_dec;
						owner_n = tid_s1;
					end
				end
				default: begin
					st_n = ST_OK;
				end
			endcase
		end else begin
			st_n = ST_NOPERM;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= KIND_NORMAL;
		end else if (cfg_valid && cfg_ready) begin
			kind_q <= mutex_kind;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1  <= operation;
			tid_s1 <= tid_ext[THREAD_ID_BITS-1:0];
		end
	end

	// mutex state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_q  <= LOCK_FREE;
			owner_q <= '0;
			count_q <= '0;
		end else if (adv) begin
			lock_q  <= lock_n;
			owner_q <= owner_n;
			count_q <= count_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_s2 <= st_n;
			wake_s2   <= wake_n;
		end
	end

endmodule
